// ===== rtl/core/gcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy change dispenser package
// Shared widths, denomination table, stock reset values, status codes and the
// structures that travel along the cell chain.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int NumDenoms     = 14;
  localparam int AmtW          = 20;  // cents, amount_due / payment / change
  localparam int IdxW          = 4;
  localparam int OutW          = 16;  // count and stock_left on the ports
  localparam int RefillW       = 8;
  localparam int StockWidthDef = 16;

  localparam logic [AmtW-1:0]    MinCoinCents = AmtW'(5);
  localparam logic [RefillW-1:0] RefillReset  = RefillW'(10);

  // Denomination values in cents, largest first.
  localparam int unsigned DENOM_CENTS [NumDenoms] = '{
    200000, 100000, 50000, 20000, 10000, 5000, 2500,
    2000, 1000, 500, 100, 50, 20, 5
  };

  localparam int unsigned STOCK_RESET [NumDenoms] = '{
    2, 2, 5, 5, 10, 10, 10, 10, 20, 20, 20, 50, 50, 50
  };

  typedef enum logic [2:0] {
    ST_DISPENSED    = 3'd0,
    ST_NO_CHANGE    = 3'd1,
    ST_INSUFFICIENT = 3'd2,
    ST_CANNOT       = 3'd3,
    ST_REFILLED     = 3'd4
  } status_e;

  // Token of the greedy walk, handed from cell to cell.
  typedef struct packed {
    logic            valid;
    logic [AmtW-1:0] rest;
    logic            used;
    logic [IdxW-1:0] last_idx;
  } chain_t;

  // Result offered by a cell while the commit token visits it.
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
    logic [OutW-1:0] count;
    logic [OutW-1:0] left;
  } result_t;

endpackage

// ===== rtl/core/greedy_change_dispenser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy change dispenser
// Makes change greedily from a limited stock of fourteen denominations and
// refills all stocks on request.
// ----------------------------------------------------------------------------
// Results are presented for exactly one cycle with result_valid_o high and
// cannot be held off, so the receiver must take every beat as it comes. A
// refill or an insufficient payment is answered in the cycle after start and
// does not raise busy. A pay item that makes change keeps the block busy
// while a token walks a row of fourteen cells, each registering a reciprocal
// multiply, then a stock limit and subtract; when nothing is dispensed its
// single result follows and busy falls in the same cycle. When coins are
// dispensed, a commit token then visits each cell in turn, giving up to
// fourteen result beats in denomination order, and busy holds until it has
// left the last cell. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module greedy_change_dispenser #(
  parameter int STOCK_WIDTH = gcd_pkg::StockWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command channel.
  input  logic                        start,
  output logic                        busy,
  input  logic                        action_i,
  input  logic [gcd_pkg::AmtW-1:0]    amount_due_i,
  input  logic [gcd_pkg::AmtW-1:0]    payment_i,
  // Configuration write channel (refill amount).
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gcd_pkg::RefillW-1:0] cfg_data_i,
  // Result strobe and fields.
  output logic                        result_valid_o,
  output logic [2:0]                  status_o,
  output logic [gcd_pkg::IdxW-1:0]    denom_index_o,
  output logic [gcd_pkg::OutW-1:0]    count_o,
  output logic [gcd_pkg::OutW-1:0]    stock_left_o,
  output logic [gcd_pkg::AmtW-1:0]    shortfall_o,
  output logic                        last_o
);
  import gcd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  typedef struct packed {
    status_e         status;
    logic [IdxW-1:0] idx;
    logic [OutW-1:0] count;
    logic [OutW-1:0] left;
    logic [AmtW-1:0] shortfall;
    logic            last;
  } out_t;

  state_e              state_q, state_d;
  logic [RefillW-1:0]  refill_q;
  chain_t              inj_q, inj_d;
  logic                cmt_start_q, cmt_start_d;
  logic [IdxW-1:0]     last_idx_q, last_idx_d;
  logic                res_valid_q, res_valid_d;
  out_t                res_q, res_d;
  logic                accept;
  logic                refill;

  chain_t              walk [NumDenoms+1];
  logic                cmt  [NumDenoms+1];
  result_t             cell_res [NumDenoms];
  result_t             res_or;

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign refill      = accept && action_i;

  // The row of cells: the walk token enters at the largest denomination.
  assign walk[0] = inj_q;
  assign cmt[0]  = cmt_start_q;

  for (genvar i = 0; i < NumDenoms; i++) begin : g_cell
    gcd_cell #(
      .STOCK_WIDTH (STOCK_WIDTH),
      .Index       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .refill_i     (refill),
      .refill_amt_i (refill_q),
      .walk_i       (walk[i]),
      .walk_o       (walk[i+1]),
      .cmt_i        (cmt[i]),
      .cmt_o        (cmt[i+1]),
      .result_o     (cell_res[i])
    );
  end

  // Only the cell holding the commit token can offer a result.
  always_comb begin
    res_or = '0;
    for (int i = 0; i < NumDenoms; i++) begin
      if (cell_res[i].valid) begin
        res_or = res_or | cell_res[i];
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    inj_d        = '0;
    cmt_start_d  = 1'b0;
    last_idx_d   = last_idx_q;
    res_valid_d  = 1'b0;
    res_d        = '{status: ST_DISPENSED, idx: '0, count: '0, left: '0,
                     shortfall: '0, last: 1'b1};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_REFILLED;
          end else if (payment_i < amount_due_i) begin
            res_valid_d  = 1'b1;
            res_d.status = ST_INSUFFICIENT;
          end else begin
            inj_d.valid = 1'b1;
            inj_d.rest  = payment_i - amount_due_i;
            state_d     = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (walk[NumDenoms].valid) begin
          if (walk[NumDenoms].rest >= MinCoinCents) begin
            // Stocks cannot cover the change: report what is left unpaid.
            res_valid_d     = 1'b1;
            res_d.status    = ST_CANNOT;
            res_d.shortfall = walk[NumDenoms].rest;
            state_d         = S_IDLE;
          end else if (!walk[NumDenoms].used) begin
            // No change, or change that rounds down to nothing.
            res_valid_d  = 1'b1;
            res_d.status = ST_NO_CHANGE;
            state_d      = S_IDLE;
          end else begin
            cmt_start_d = 1'b1;
            last_idx_d  = walk[NumDenoms].last_idx;
            state_d     = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        if (res_or.valid) begin
          res_valid_d = 1'b1;
          res_d.idx   = res_or.idx;
          res_d.count = res_or.count;
          res_d.left  = res_or.left;
          res_d.last  = (res_or.idx == last_idx_q);
        end
        if (cmt[NumDenoms]) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      refill_q    <= RefillReset;
      inj_q       <= '0;
      cmt_start_q <= 1'b0;
      last_idx_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inj_q       <= inj_d;
      cmt_start_q <= cmt_start_d;
      last_idx_q  <= last_idx_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        refill_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_q.status;
  assign denom_index_o  = res_q.idx;
  assign count_o        = res_q.count;
  assign stock_left_o   = res_q.left;
  assign shortfall_o    = res_q.shortfall;
  assign last_o         = res_q.last;

endmodule

// ===== rtl/core/gcd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy change dispenser cell
// Holds the stock of one denomination. Takes its share of the change as the
// walk token passes, and applies it when the commit token passes.
// ----------------------------------------------------------------------------
module gcd_cell #(
  parameter int STOCK_WIDTH = gcd_pkg::StockWidthDef,
  parameter int Index       = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        refill_i,
  input  logic [gcd_pkg::RefillW-1:0] refill_amt_i,
  input  gcd_pkg::chain_t             walk_i,
  output gcd_pkg::chain_t             walk_o,
  input  logic                        cmt_i,
  output logic                        cmt_o,
  output gcd_pkg::result_t            result_o
);
  import gcd_pkg::*;

  localparam int unsigned Denom = DENOM_CENTS[Index];
  localparam int Shift  = AmtW + $clog2(Denom);
  localparam int RecipW = AmtW + 2;
  // Rounded-up reciprocal: exact floor division for every AmtW-bit dividend.
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(Denom) - 64'd1) / 64'(Denom));
  localparam int CmpW = (STOCK_WIDTH > AmtW) ? STOCK_WIDTH : AmtW;

  logic [STOCK_WIDTH-1:0]   stock_q;
  logic [AmtW-1:0]          take_q;
  chain_t                   st1_q;
  logic [AmtW-1:0]          quo_q;
  chain_t                   walk_q;
  logic                     cmt_q;

  logic [AmtW+RecipW-1:0]   prod1;
  logic [AmtW-1:0]          quo_d;
  logic [CmpW-1:0]          quo_x;
  logic [CmpW-1:0]          stk_x;
  logic [AmtW-1:0]          give;
  logic [2*AmtW-1:0]        prod2;
  logic [STOCK_WIDTH:0]     sum;
  logic [STOCK_WIDTH-1:0]   sat;
  logic [STOCK_WIDTH-1:0]   left_full;

  // Stage one: quotient of the incoming rest by this denomination.
  assign prod1 = {{RecipW{1'b0}}, walk_i.rest} * {{AmtW{1'b0}}, Recip};
  assign quo_d = AmtW'(prod1 >> Shift);

  // Stage two: limit by stock and take the paid part off the rest.
  assign quo_x = CmpW'(quo_q);
  assign stk_x = CmpW'(stock_q);
  assign give  = AmtW'((quo_x < stk_x) ? quo_x : stk_x);
  assign prod2 = {{AmtW{1'b0}}, give} * (2*AmtW)'(Denom);

  assign sum = {1'b0, stock_q} + (STOCK_WIDTH+1)'(refill_amt_i);
  assign sat = sum[STOCK_WIDTH] ? {STOCK_WIDTH{1'b1}} : sum[STOCK_WIDTH-1:0];

  assign left_full = stock_q - STOCK_WIDTH'(take_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stock_q <= STOCK_WIDTH'(STOCK_RESET[Index]);
      st1_q   <= '0;
      walk_q  <= '0;
      cmt_q   <= 1'b0;
    end else begin
      st1_q        <= walk_i;
      walk_q.valid <= st1_q.valid;
      walk_q.rest  <= st1_q.rest - prod2[AmtW-1:0];
      walk_q.used  <= st1_q.used | (give != '0);
      walk_q.last_idx <= (give != '0) ? IdxW'(Index) : st1_q.last_idx;
      cmt_q        <= cmt_i;
      if (refill_i) begin
        stock_q <= sat;
      end else if (cmt_i) begin
        stock_q <= left_full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    if (st1_q.valid) begin
      take_q <= give;
    end
  end

  assign walk_o = walk_q;
  assign cmt_o  = cmt_q;

  assign result_o.valid = cmt_i && (take_q != '0);
  assign result_o.idx   = IdxW'(Index);
  assign result_o.count = OutW'(take_q);
  assign result_o.left  = OutW'(left_full);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy change dispenser testbench
// Drives pay and refill commands into the dispenser and checks every result
// beat against a cycle-free model of the greedy walk and the coin stocks. A
// directed pass covers the field extremes and the special cases. Random
// phases follow under several refill settings and sender idle rates, ending
// with refills at the largest amount and payouts from the topped-up stocks.
// ----------------------------------------------------------------------------
module tb;
  import gcd_pkg::*;

  // Cycles allowed without any beat on any channel before the run is aborted.
  // The limit covers the busy time of the slowest item, with margin for sender
  // gaps and the settle time between phases.
  localparam int unsigned WatchdogLimit = 4000;
  // Quiet cycles after the last expected beat, longer than the busy window of
  // a dispensing pay item.
  localparam int unsigned SettleCycles  = 60;
  localparam logic [AmtW-1:0] AmtMax    = {AmtW{1'b1}};

  // One command for the dispenser. drain_first holds the command back until
  // every result owed for earlier commands has come out.
  typedef struct {
    logic            act;
    logic [AmtW-1:0] due;
    logic [AmtW-1:0] paid;
    bit              drain_first;
  } sale_t;

  // One result beat the dispenser owes, tagged with the cycle number of the
  // edge at which its command was taken.
  typedef struct {
    status_e         status;
    logic [IdxW-1:0] idx;
    logic [OutW-1:0] cnt;
    logic [OutW-1:0] left;
    logic [AmtW-1:0] short_c;
    logic            last;
    int unsigned     tag;
  } coin_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               start = 1'b0;
  logic               busy;
  logic               action = 1'b0;
  logic [AmtW-1:0]    amount_due = '0;
  logic [AmtW-1:0]    payment = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RefillW-1:0] cfg_data = '0;
  logic               res_valid;
  logic [2:0]         status;
  logic [IdxW-1:0]    denom_index;
  logic [OutW-1:0]    count;
  logic [OutW-1:0]    stock_left;
  logic [AmtW-1:0]    shortfall;
  logic               last;

  // Model state: coin stocks and the refill amount as the block should hold them.
  logic [OutW-1:0]    coin_stock [NumDenoms];
  logic [RefillW-1:0] refill_units;

  sale_t       sales_waiting [$];
  coin_beat_t  owed_beats [$];
  sale_t       cur_sale;
  int unsigned sender_idle_pct = 0;
  int unsigned beats_owed_total = 0;   // owned by the driver
  int unsigned beats_paid_total = 0;   // owned by the monitor, updated by NBA
  int unsigned cyc = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  greedy_change_dispenser dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .action_i       (action),
    .amount_due_i   (amount_due),
    .payment_i      (payment),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .result_valid_o (res_valid),
    .status_o       (status),
    .denom_index_o  (denom_index),
    .count_o        (count),
    .stock_left_o   (stock_left),
    .shortfall_o    (shortfall),
    .last_o         (last)
  );

  task automatic flag_error(input string msg);
    $display("ERROR t=%0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic void owe_beat(input status_e st, input int unsigned idx,
                                   input int unsigned cnt, input int unsigned left,
                                   input int unsigned short_c, input bit is_last,
                                   input int unsigned tag);
    coin_beat_t b;
    b.status  = st;
    b.idx     = IdxW'(idx);
    b.cnt     = OutW'(cnt);
    b.left    = OutW'(left);
    b.short_c = AmtW'(short_c);
    b.last    = is_last;
    b.tag     = tag;
    owed_beats.push_back(b);
  endfunction

  // Works out the beats one accepted command must produce and updates the
  // model stocks. Returns the number of beats owed.
  function automatic int settle_sale(input sale_t s, input int unsigned tag);
    int unsigned rest;
    int unsigned want;
    int unsigned give [NumDenoms];
    int          used;
    int          n;
    logic [OutW:0] sum;
    if (s.act) begin
      // A refill tops up every stock, clipping at the all-ones value.
      for (int i = 0; i < NumDenoms; i++) begin
        sum = {1'b0, coin_stock[i]} + (OutW+1)'(refill_units);
        coin_stock[i] = sum[OutW] ? {OutW{1'b1}} : sum[OutW-1:0];
      end
      owe_beat(ST_REFILLED, 0, 0, 0, 0, 1'b1, tag);
      return 1;
    end
    if (s.paid < s.due) begin
      owe_beat(ST_INSUFFICIENT, 0, 0, 0, 0, 1'b1, tag);
      return 1;
    end
    // Greedy walk, largest coin first, each take limited by what is in stock.
    rest = s.paid - s.due;
    used = 0;
    for (int i = 0; i < NumDenoms; i++) begin
      want    = rest / DENOM_CENTS[i];
      give[i] = (want < coin_stock[i]) ? want : coin_stock[i];
      rest   -= give[i] * DENOM_CENTS[i];
      if (give[i] != 0) used++;
    end
    // Five cents or more left over: nothing leaves the drawer.
    if (rest >= MinCoinCents) begin
      owe_beat(ST_CANNOT, 0, 0, 0, rest, 1'b1, tag);
      return 1;
    end
    // Zero change, or change under five cents that rounds away.
    if (used == 0) begin
      owe_beat(ST_NO_CHANGE, 0, 0, 0, 0, 1'b1, tag);
      return 1;
    end
    n = 0;
    for (int i = 0; i < NumDenoms; i++) begin
      if (give[i] != 0) begin
        coin_stock[i] = coin_stock[i] - OutW'(give[i]);
        owe_beat(ST_DISPENSED, i, give[i], coin_stock[i], 0, (n + 1 == used), tag);
        n++;
      end
    end
    return n;
  endfunction

  // Random commands, weighted so that most pay items actually reach the
  // greedy walk and deplete the stocks, with refills to bring them back.
  function automatic sale_t random_sale();
    sale_t       s;
    int unsigned pick;
    int unsigned change;
    pick          = $urandom_range(0, 99);
    s.act         = 1'b0;
    s.due         = AmtW'($urandom());
    s.paid        = AmtW'($urandom());
    s.drain_first = ($urandom_range(0, 99) < 4);
    if (pick < 14) begin
      s.act = 1'b1;
    end else if (pick < 24) begin
      s.due  = AmtW'($urandom_range(1, AmtMax));
      s.paid = AmtW'($urandom_range(0, s.due - 1));
    end else if (pick < 32) begin
      s.due  = AmtW'($urandom_range(0, AmtMax - 4));
      s.paid = s.due + AmtW'($urandom_range(0, 4));
    end else if (pick < 75) begin
      s.due  = AmtW'($urandom_range(0, 400000));
      change = 5 * $urandom_range(1, 2000) + $urandom_range(0, 4);
      s.paid = s.due + AmtW'(change);
    end else if (pick < 93) begin
      s.due  = AmtW'($urandom_range(0, 2000));
      s.paid = AmtW'($urandom_range(s.due, AmtMax));
    end else begin
      s.act = 1'($urandom_range(0, 1));
    end
    return s;
  endfunction

  function automatic void queue_sale(input logic act, input int unsigned due,
                                     input int unsigned paid, input bit drain_first);
    sale_t s;
    s.act         = act;
    s.due         = AmtW'(due);
    s.paid        = AmtW'(paid);
    s.drain_first = drain_first;
    sales_waiting.push_back(s);
  endfunction

  // Writes the refill amount. Only called with the block idle.
  task automatic write_refill(input logic [RefillW-1:0] units);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= units;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid    <= 1'b0;
    refill_units  = units;
  endtask

  // Waits at falling edges, where everything has settled, until every command
  // has gone in and every owed beat has come out, then lets the block go quiet.
  task automatic wait_drained();
    do @(negedge clk);
    while (sales_waiting.size() != 0 || start || owed_beats.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_phase(input int n_items, input int unsigned idle_pct,
                           input logic [RefillW-1:0] units, input bit force_drain);
    sale_t s;
    write_refill(units);
    @(negedge clk);
    sender_idle_pct = idle_pct;
    for (int k = 0; k < n_items; k++) begin
      s = random_sale();
      // Halfway through, hold the sender off until the block has caught up.
      if (force_drain && k == n_items / 2) s.drain_first = 1'b1;
      sales_waiting.push_back(s);
    end
    wait_drained();
  endtask

  // Driver. A command beat is taken at an edge where start is high and busy
  // is low; the model is advanced at that edge. When the slot is free, the
  // next command is offered unless the sender idles this cycle or the
  // command must wait for the block to drain. The drain test compares the
  // driver's own count, already advanced at this edge, with the monitor's
  // registered count, which still holds its value from before the edge.
  always @(posedge clk or negedge rst_n) begin : drive_sales
    bit go;
    if (!rst_n) begin
      start      <= 1'b0;
      action     <= 1'b0;
      amount_due <= '0;
      payment    <= '0;
    end else begin
      if (start && !busy) beats_owed_total += settle_sale(cur_sale, cyc);
      if (!start || !busy) begin
        go = 1'b0;
        if (sales_waiting.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          if (!sales_waiting[0].drain_first || beats_owed_total == beats_paid_total)
            go = 1'b1;
        end
        if (go) begin
          cur_sale    = sales_waiting.pop_front();
          action     <= cur_sale.act;
          amount_due <= cur_sale.due;
          payment    <= cur_sale.paid;
        end
        start <= go;
      end
    end
  end

  // Monitor. Every strobed beat is taken at the edge that ends its cycle and
  // matched against the oldest owed beat. An owed beat whose command was
  // taken at this very edge cannot be answered yet, so its tag must be older
  // than the current cycle number; this keeps the check independent of
  // which always block runs first.
  always @(posedge clk) begin : check_beats
    coin_beat_t want;
    if (rst_n && res_valid === 1'b1) begin
      if (owed_beats.size() == 0 || owed_beats[0].tag >= cyc) begin
        flag_error($sformatf("result beat with nothing owed: status %0d denom %0d count %0d",
                             status, denom_index, count));
      end else begin
        want = owed_beats.pop_front();
        beats_paid_total <= beats_paid_total + 1;
        if (status !== want.status)
          flag_error($sformatf("status %0d, expected %0d", status, want.status));
        if (denom_index !== want.idx)
          flag_error($sformatf("denom_index %0d, expected %0d", denom_index, want.idx));
        if (count !== want.cnt)
          flag_error($sformatf("count %0d, expected %0d", count, want.cnt));
        if (stock_left !== want.left)
          flag_error($sformatf("stock_left %0d, expected %0d", stock_left, want.left));
        if (shortfall !== want.short_c)
          flag_error($sformatf("shortfall %0d, expected %0d", shortfall, want.short_c));
        if (last !== want.last)
          flag_error($sformatf("last %0d, expected %0d", last, want.last));
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cyc          <= 0;
      quiet_cycles <= 0;
    end else begin
      cyc <= cyc + 1;
      if ((start && !busy) || res_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WatchdogLimit) begin
        $display("greedy_change_dispenser verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : sequencer
    for (int i = 0; i < NumDenoms; i++) coin_stock[i] = OutW'(STOCK_RESET[i]);
    refill_units    = RefillReset;
    sender_idle_pct = 20;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pass with the refill amount still at its reset value.
    queue_sale(1'b0, 0, 391175, 1'b0);       // nine denominations, two of 20000: 9 beats
    queue_sale(1'b0, 0, 0, 1'b0);            // zero change
    queue_sale(1'b0, AmtMax, AmtMax, 1'b0);  // zero change at the top of the range
    queue_sale(1'b0, 1, 0, 1'b0);            // paid one cent short
    queue_sale(1'b0, AmtMax, 0, 1'b0);       // nothing paid against the maximum
    queue_sale(1'b0, 0, 3, 1'b0);            // change under five cents rounds away
    queue_sale(1'b0, 0, 4, 1'b0);
    queue_sale(1'b0, 0, 5, 1'b0);            // smallest coin alone
    queue_sale(1'b0, 100, 385, 1'b0);
    queue_sale(1'b0, 12345, 54321, 1'b0);
    queue_sale(1'b0, 0, AmtMax, 1'b0);       // largest change, more than the stocks hold: shortfall
    queue_sale(1'b0, 0, AmtMax, 1'b0);       // stock still too thin: shortfall
    queue_sale(1'b1, 0, 0, 1'b0);
    queue_sale(1'b0, 0, 7, 1'b0);            // one coin, two cents dropped
    queue_sale(1'b0, 0, AmtMax, 1'b1);
    queue_sale(1'b1, AmtMax, 1, 1'b0);       // refill ignores the amount fields
    wait_drained();

    // Refill amount at its lower extreme: a refill leaves the stocks alone.
    write_refill('0);
    @(negedge clk);
    queue_sale(1'b1, 0, 0, 1'b0);
    queue_sale(1'b0, 0, 15, 1'b0);
    queue_sale(1'b0, 0, AmtMax, 1'b0);
    wait_drained();

    // Random phases: sender idling often, then very often, then never.
    run_phase(50, 20, RefillW'($urandom_range(1, 254)), 1'b0);
    run_phase(50, 54, {RefillW{1'b1}}, 1'b1);
    run_phase(30, 0, RefillW'(1), 1'b0);

    // Refills at the upper extreme, then payouts from the topped-up stocks
    // and one more refill.
    write_refill({RefillW{1'b1}});
    @(negedge clk);
    for (int k = 0; k < 6; k++) queue_sale(1'b1, 0, 0, 1'b0);
    queue_sale(1'b0, 0, AmtMax, 1'b0);
    queue_sale(1'b0, 0, 391175, 1'b0);
    queue_sale(1'b1, 0, 0, 1'b0);
    queue_sale(1'b0, 777, 90210, 1'b0);
    wait_drained();

    if (owed_beats.size() != 0)
      flag_error($sformatf("%0d result beats never arrived", owed_beats.size()));
    if (n_errors == 0) begin
      $display("greedy_change_dispenser verification clean");
    end else begin
      $display("greedy_change_dispenser verification failed");
    end
    $finish;
  end

endmodule
